@@ hw/rtl/sbn_pkg.sv @@
// Package for the S-box branch number block: shared constants, widths and
// the controller state type. No dependencies.
package sbn_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_ENTRIES_DEF = 256;
    localparam int ENTRY_BITS_DEF  = 8;

    // Fixed port widths
    localparam int VALUE_W = 8;
    localparam int BN_W    = 7;

    // Running minimum before any pair is seen
    localparam logic [BN_W-1:0] INIT_MIN = BN_W'(100);

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

endpackage

@@ hw/rtl/sbn_cell.sv @@
// One storage cell of the entry ring: holds one stored S-box entry and
// passes it to its neighbor on every shift. Depends on sbn_pkg.
module sbn_cell #(
    parameter int ENTRY_BITS = sbn_pkg::ENTRY_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  shift_en,
    input  logic [ENTRY_BITS-1:0] d,
    output logic [ENTRY_BITS-1:0] q
);

    logic [ENTRY_BITS-1:0] entry_reg;

    // Entry register, payload only, no reset
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

@@ hw/rtl/sbn_pair_weight.sv @@
// Pair weight unit: popcount(pos ^ idx) + popcount(a ^ b).
// Depends on sbn_pkg for default widths.
module sbn_pair_weight #(
    parameter int IDX_W      = 8,
    parameter int ENTRY_BITS = sbn_pkg::ENTRY_BITS_DEF,
    parameter int WT_W       = 5
) (
    input  logic [IDX_W-1:0]      pos,
    input  logic [IDX_W-1:0]      idx,
    input  logic [ENTRY_BITS-1:0] value_a,
    input  logic [ENTRY_BITS-1:0] value_b,
    output logic [WT_W-1:0]       weight
);

    logic [IDX_W-1:0]      idx_diff;
    logic [ENTRY_BITS-1:0] val_diff;
    logic [WT_W-1:0]       idx_ones;
    logic [WT_W-1:0]       val_ones;

    assign idx_diff = pos ^ idx;
    assign val_diff = value_a ^ value_b;

    // Bit counts of both differences
    always_comb
    begin
        idx_ones = '0;
        for (int i = 0; i < IDX_W; i++)
        begin
            idx_ones = idx_ones + WT_W'(idx_diff[i]);
        end
        val_ones = '0;
        for (int i = 0; i < ENTRY_BITS; i++)
        begin
            val_ones = val_ones + WT_W'(val_diff[i]);
        end
    end

    assign weight = idx_ones + val_ones;

endmodule

@@ hw/rtl/sbox_branch_number_top.sv @@
// S-box differential branch number, top level: entry ring, pair weight unit
// and sweep controller. Depends on sbn_pkg, sbn_cell, sbn_pair_weight.
//
// Words are S-box outputs in input order, taken when start is high and busy
// is low. For a stored word the entry ring of MAX_ENTRIES cells rotates
// once, one stored entry reaching the pair weight unit per cycle, and the
// new word is dropped into its slot as the ring passes it. A word that
// arrives with the table full skips the rotation and only sets the overflow
// flag. On a word marked last, done pulses for one cycle with branch_number
// and table_overflow; the receiver cannot stall, so the result must be taken
// in that cycle. The table then starts over. No clearing pass is needed
// after reset.
module sbox_branch_number_top #(
    parameter int MAX_ENTRIES = sbn_pkg::MAX_ENTRIES_DEF,
    parameter int ENTRY_BITS  = sbn_pkg::ENTRY_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [sbn_pkg::VALUE_W-1:0] sbox_value,
    input  logic                     last_value,
    output logic                     done,
    output logic [sbn_pkg::BN_W-1:0] branch_number,
    output logic                     table_overflow
);

    localparam int IDX_W = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int WT_W  = $clog2(IDX_W + ENTRY_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ENTRIES);
    localparam logic [IDX_W-1:0] STEP_END = IDX_W'(MAX_ENTRIES - 1);

    sbn_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [IDX_W-1:0]        step_reg, step_next;
    logic [ENTRY_BITS-1:0]   value_reg, value_next;
    logic                    last_reg, last_next;
    logic [sbn_pkg::BN_W-1:0] min_reg, min_next;
    logic                    ovf_reg, ovf_next;
    logic                    done_reg, done_next;
    logic [sbn_pkg::BN_W-1:0] bn_reg, bn_next;
    logic                    tovf_reg, tovf_next;

    logic                    accept;
    logic                    table_full;
    logic                    sweep_en;
    logic [ENTRY_BITS-1:0]   value_in;
    logic [ENTRY_BITS-1:0]   ring_head;
    logic [ENTRY_BITS-1:0]   ring_feed;
    logic [WT_W-1:0]         weight;
    logic [ENTRY_BITS-1:0]   ring_q [MAX_ENTRIES];

    assign accept     = start && !busy;
    assign table_full = (count_reg == CNT_FULL);

    // Low ENTRY_BITS bits of the incoming word, zero-extended
    always_comb
    begin
        value_in = '0;
        for (int i = 0; i < ENTRY_BITS; i++)
        begin
            if (i < sbn_pkg::VALUE_W)
            begin
                value_in[i] = sbox_value[i];
            end
        end
    end

    // Entry ring: cell 0 is the head, the tail takes the feedback
    assign ring_head = ring_q[0];
    assign ring_feed = (step_reg == pos_reg) ? value_reg : ring_head;

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        if (g == MAX_ENTRIES - 1)
        begin : g_tail
            sbn_cell #(
                .ENTRY_BITS(ENTRY_BITS)
            ) u_cell (
                .clk     (clk),
                .shift_en(sweep_en),
                .d       (ring_feed),
                .q       (ring_q[g])
            );
        end
        else
        begin : g_body
            sbn_cell #(
                .ENTRY_BITS(ENTRY_BITS)
            ) u_cell (
                .clk     (clk),
                .shift_en(sweep_en),
                .d       (ring_q[g+1]),
                .q       (ring_q[g])
            );
        end
    end

    sbn_pair_weight #(
        .IDX_W     (IDX_W),
        .ENTRY_BITS(ENTRY_BITS),
        .WT_W      (WT_W)
    ) u_weight (
        .pos    (pos_reg),
        .idx    (step_reg),
        .value_a(value_reg),
        .value_b(ring_head),
        .weight (weight)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sbn_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = table_full ? sbn_pkg::ST_FINISH : sbn_pkg::ST_SWEEP;
                end
            end
            sbn_pkg::ST_SWEEP:
            begin
                if (step_reg == STEP_END)
                begin
                    state_next = sbn_pkg::ST_FINISH;
                end
            end
            sbn_pkg::ST_FINISH:
            begin
                state_next = sbn_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sbn_pkg::ST_IDLE;
            end
        endcase
    end

    // Controller outputs
    always_comb
    begin
        busy     = 1'b1;
        sweep_en = 1'b0;
        case (state_reg)
            sbn_pkg::ST_IDLE:
            begin
                busy = 1'b0;
            end
            sbn_pkg::ST_SWEEP:
            begin
                sweep_en = 1'b1;
            end
            sbn_pkg::ST_FINISH:
            begin
                busy = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        count_next = count_reg;
        pos_next   = pos_reg;
        step_next  = step_reg;
        value_next = value_reg;
        last_next  = last_reg;
        min_next   = min_reg;
        ovf_next   = ovf_reg;
        done_next  = 1'b0;
        bn_next    = bn_reg;
        tovf_next  = tovf_reg;

        if (accept)
        begin
            value_next = value_in;
            last_next  = last_value;
            step_next  = '0;
            if (table_full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                pos_next   = count_reg[IDX_W-1:0];
                count_next = count_reg + CNT_W'(1);
            end
        end

        // One stored entry per cycle against the new word
        if (sweep_en)
        begin
            step_next = step_reg + IDX_W'(1);
            if ((step_reg < pos_reg) && (sbn_pkg::BN_W'(weight) < min_reg))
            begin
                min_next = sbn_pkg::BN_W'(weight);
            end
        end

        // Emit on the last word and start a new table
        if ((state_reg == sbn_pkg::ST_FINISH) && last_reg)
        begin
            done_next  = 1'b1;
            bn_next    = min_reg;
            tovf_next  = ovf_reg;
            count_next = '0;
            min_next   = sbn_pkg::INIT_MIN;
            ovf_next   = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbn_pkg::ST_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
            min_reg   <= sbn_pkg::INIT_MIN;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            min_reg   <= min_next;
            ovf_reg   <= ovf_next;
            done_reg  <= done_next;
            last_reg  <= last_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        value_reg <= value_next;
        bn_reg    <= bn_next;
        tovf_reg  <= tovf_next;
    end

    assign done           = done_reg;
    assign branch_number  = bn_reg;
    assign table_overflow = tovf_reg;

    // A result only follows the finish step of a word marked last
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == sbn_pkg::ST_FINISH) && $past(last_reg))
        else $error("done without a finishing last word");

    // The sweep index advances by one each cycle of a rotation
    a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sbn_pkg::ST_SWEEP) && (step_reg != STEP_END)
        |=> (state_reg == sbn_pkg::ST_SWEEP) && (step_reg == $past(step_reg) + IDX_W'(1)))
        else $error("sweep index skipped");

    // A word taken with the table full is dropped without a sweep
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && table_full |=> (state_reg == sbn_pkg::ST_FINISH) && ovf_reg)
        else $error("word beyond capacity not dropped");

    // The reported minimum stays in its range
    a_bn_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (branch_number != '0) && (branch_number <= sbn_pkg::INIT_MIN))
        else $error("branch number out of range");

endmodule
